[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/svrbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package svrbp_pkg;

   localparam int COORD_W       = 31;
   localparam int DELTA_W       = 17;
   localparam int INDEX_W       = 8;
   localparam int CSR_W         = 4;
   localparam int ACC_W         = 48;
   localparam int CNT_W         = 6;
   localparam int STEP_W        = 3;
   localparam int NB_W          = 5;
   localparam int EDGE_MAX_BITS = 17;
   localparam int MOVE_MAX_BITS = 31;
   localparam int INDEX_MAX     = 8;

   localparam logic [0:0] CSR_FILL_BITS = 1'b0;
   localparam logic [0:0] CSR_LINE_BITS = 1'b1;

   typedef enum logic [1:0] {
      OP_STYLE = 2'd0,
      OP_LINE  = 2'd1,
      OP_CURVE = 2'd2,
      OP_END   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      LINE_HORIZ   = 2'd0,
      LINE_VERT    = 2'd1,
      LINE_GENERAL = 2'd2
   } line_form_type;

   // One classified record, as queued between front and back.
   typedef struct packed {
      logic                 error;
      opcode_type           op;
      logic [3:0]           flags;
      logic [NB_W-1:0]      n;
      line_form_type        form;
      logic [STEP_W-1:0]    last_step;
      logic [CSR_W-1:0]     fill_w;
      logic [CSR_W-1:0]     line_w;
      logic [COORD_W-1:0]   fx;
      logic [COORD_W-1:0]   fy;
      logic [DELTA_W-1:0]   sx;
      logic [DELTA_W-1:0]   sy;
      logic [INDEX_W-1:0]   lf;
      logic [INDEX_W-1:0]   rf;
      logic [INDEX_W-1:0]   ls;
   } rec_type;

   // Least two's-complement width that holds v.
   function automatic logic [NB_W-1:0] swidth(input logic [COORD_W-1:0] v);
      logic [COORD_W-1:0] u;
      logic [NB_W-1:0]    n;
      u = v[COORD_W-1] ? ~v : v;
      n = NB_W'(1);
      for (int i = 0; i < COORD_W - 1; i++) begin
         if (u[i]) n = NB_W'(i + 2);
      end
      return n;
   endfunction

   function automatic logic [NB_W-1:0] wmax(input logic [NB_W-1:0] a,
                                            input logic [NB_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage

`default_nettype wire

[hdl/svrbp_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface svrbp_req_if import svrbp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                opcode;
   logic [4:0]                style_flags;
   logic signed [COORD_W-1:0] first_x;
   logic signed [COORD_W-1:0] first_y;
   logic signed [DELTA_W-1:0] second_x;
   logic signed [DELTA_W-1:0] second_y;
   logic [INDEX_W-1:0]        left_fill;
   logic [INDEX_W-1:0]        right_fill;
   logic [INDEX_W-1:0]        line_style;

   modport source (output valid, opcode, style_flags, first_x, first_y, second_x,
                   second_y, left_fill, right_fill, line_style, input ready);
   modport sink   (input valid, opcode, style_flags, first_x, first_y, second_x,
                   second_y, left_fill, right_fill, line_style, output ready);
endinterface

interface svrbp_rsp_if import svrbp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] out_byte;
   logic               last;
   logic               error;

   modport source (output valid, out_byte, last, error, input ready);
   modport sink   (input valid, out_byte, last, error, output ready);
endinterface

`default_nettype wire

[hdl/svrbp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module svrbp_front import svrbp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   svrbp_req_if.sink        req,
   input  logic             csr_write_enable,
   input  logic [0:0]       csr_index,
   input  logic [CSR_W-1:0] csr_write_data,
   input  logic             q_full,
   output logic             q_push,
   output rec_type          q_rec
);

   logic [CSR_W-1:0]   fill_bits_ff, fill_bits_in;
   logic [CSR_W-1:0]   line_bits_ff, line_bits_in;
   opcode_type         op;
   logic [3:0]         flags;
   logic [NB_W-1:0]    sw_fx, sw_fy, sw_sx, sw_sy, n_first, n_curve, n;
   logic               fx_zero, fy_zero, sx_zero, sy_zero;
   logic               empty, err;
   logic [STEP_W-1:0]  last_step;
   line_form_type      form;

   always_comb begin
      fill_bits_in = fill_bits_ff;
      line_bits_in = line_bits_ff;
      if (csr_write_enable && csr_index == CSR_FILL_BITS) fill_bits_in = csr_write_data;
      if (csr_write_enable && csr_index == CSR_LINE_BITS) line_bits_in = csr_write_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_bits_ff <= '0;
         line_bits_ff <= '0;
      end else begin
         fill_bits_ff <= fill_bits_in;
         line_bits_ff <= line_bits_in;
      end
   end

   assign op      = opcode_type'(req.opcode);
   assign flags   = req.style_flags[3:0];
   assign fx_zero = (req.first_x == '0);
   assign fy_zero = (req.first_y == '0);
   assign sx_zero = (req.second_x == '0);
   assign sy_zero = (req.second_y == '0);
   assign sw_fx   = swidth(req.first_x);
   assign sw_fy   = swidth(req.first_y);
   assign sw_sx   = swidth({{(COORD_W-DELTA_W){req.second_x[DELTA_W-1]}}, req.second_x});
   assign sw_sy   = swidth({{(COORD_W-DELTA_W){req.second_y[DELTA_W-1]}}, req.second_y});
   assign n_first = wmax(sw_fx, sw_fy);
   assign n_curve = wmax(n_first, wmax(sw_sx, sw_sy));

   // Classify: drop empty records, flag over-wide ones, pick the line form.
   always_comb begin
      empty     = 1'b0;
      err       = 1'b0;
      n         = '0;
      form      = LINE_GENERAL;
      last_step = STEP_W'(1);
      case (op)
         OP_STYLE: begin
            empty = (flags == 4'd0);
            n     = flags[0] ? n_first : '0;
            err   = flags[0] && ({1'b0, n} > 6'(MOVE_MAX_BITS));
            if (flags[3])      last_step = STEP_W'(6);
            else if (flags[2]) last_step = STEP_W'(5);
            else if (flags[1]) last_step = STEP_W'(4);
            else               last_step = STEP_W'(3);
         end
         OP_LINE: begin
            empty = fx_zero && fy_zero;
            n     = wmax(n_first, NB_W'(2));
            err   = n > NB_W'(EDGE_MAX_BITS);
            if (fx_zero)      form = LINE_VERT;
            else if (fy_zero) form = LINE_HORIZ;
            else              form = LINE_GENERAL;
            last_step = (form == LINE_GENERAL) ? STEP_W'(2) : STEP_W'(1);
         end
         OP_CURVE: begin
            empty     = fx_zero && fy_zero && sx_zero && sy_zero;
            n         = wmax(n_curve, NB_W'(2));
            err       = n > NB_W'(EDGE_MAX_BITS);
            last_step = STEP_W'(4);
         end
         default: begin
            last_step = STEP_W'(1);
         end
      endcase
   end

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full && !empty;

   always_comb begin
      q_rec.error     = err;
      q_rec.op        = op;
      q_rec.flags     = flags;
      q_rec.n         = n;
      q_rec.form      = form;
      q_rec.last_step = last_step;
      q_rec.fill_w    = (fill_bits_ff > CSR_W'(INDEX_MAX)) ? CSR_W'(INDEX_MAX) : fill_bits_ff;
      q_rec.line_w    = (line_bits_ff > CSR_W'(INDEX_MAX)) ? CSR_W'(INDEX_MAX) : line_bits_ff;
      q_rec.fx        = req.first_x;
      q_rec.fy        = req.first_y;
      q_rec.sx        = req.second_x;
      q_rec.sy        = req.second_y;
      q_rec.lf        = req.left_fill;
      q_rec.rf        = req.right_fill;
      q_rec.ls        = req.line_style;
   end

endmodule

`default_nettype wire

[hdl/svrbp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module svrbp_queue import svrbp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output rec_type head
);

   rec_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_rec;
   end

   `ASSERT_IMPLIES(a_no_overflow, clock, reset, count_ff == 2'd2, !push, "queue overflow")
   `ASSERT_IMPLIES(a_no_underflow, clock, reset, count_ff == 2'd0, !pop, "queue underflow")

endmodule

`default_nettype wire

[hdl/svrbp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module svrbp_back import svrbp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  rec_type   q_head,
   output logic      q_pop,
   svrbp_rsp_if.source rsp
);

   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               active_ff, active_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_error_ff, rsp_error_in;

   logic               out_free, emit, err_go, can_start, app, fin;
   logic [CNT_W-1:0]   cnt_base;
   logic [CNT_W:0]     sum;
   logic [COORD_W-1:0] seg_val, seg_masked, sx_ext, sy_ext;
   logic [CNT_W-1:0]   seg_w;
   logic [3:0]         nm2;
   logic [2:0]         pad;
   logic [ACC_W-1:0]   acc_down;

   assign out_free = !rsp_valid_ff || rsp.ready;
   // While a record is open, hold a byte that may be its last until a second
   // whole byte stands behind it or the record is closed.
   assign emit     = out_free && (active_ff ? (cnt_ff >= CNT_W'(16)) : (cnt_ff >= CNT_W'(8)));
   assign cnt_base = emit ? (cnt_ff - CNT_W'(8)) : cnt_ff;
   assign acc_down = acc_ff >> (cnt_ff - CNT_W'(8));
   assign nm2      = 4'(q_head.n - NB_W'(2));
   assign pad      = 3'(3'd0 - cnt_base[2:0]);
   assign sx_ext   = {{(COORD_W-DELTA_W){q_head.sx[DELTA_W-1]}}, q_head.sx};
   assign sy_ext   = {{(COORD_W-DELTA_W){q_head.sy[DELTA_W-1]}}, q_head.sy};

   // Field for the current step of the head record.
   always_comb begin
      seg_val = '0;
      seg_w   = '0;
      case (q_head.op)
         OP_STYLE: begin
            case (step_ff)
               3'd0: begin
                  seg_val = {27'd0, q_head.flags};
                  seg_w   = CNT_W'(6);
               end
               3'd1: begin
                  seg_val = {26'd0, q_head.n};
                  seg_w   = q_head.flags[0] ? CNT_W'(5) : '0;
               end
               3'd2: begin
                  seg_val = q_head.fx;
                  seg_w   = q_head.flags[0] ? CNT_W'(q_head.n) : '0;
               end
               3'd3: begin
                  seg_val = q_head.fy;
                  seg_w   = q_head.flags[0] ? CNT_W'(q_head.n) : '0;
               end
               3'd4: begin
                  seg_val = {23'd0, q_head.lf};
                  seg_w   = q_head.flags[1] ? CNT_W'(q_head.fill_w) : '0;
               end
               3'd5: begin
                  seg_val = {23'd0, q_head.rf};
                  seg_w   = q_head.flags[2] ? CNT_W'(q_head.fill_w) : '0;
               end
               3'd6: begin
                  seg_val = {23'd0, q_head.ls};
                  seg_w   = q_head.flags[3] ? CNT_W'(q_head.line_w) : '0;
               end
               default: begin
                  seg_val = '0;
                  seg_w   = '0;
               end
            endcase
         end
         OP_LINE: begin
            case (step_ff)
               3'd0: begin
                  case (q_head.form)
                     LINE_HORIZ: begin
                        seg_val = {23'd0, 2'b11, nm2, 2'b00};
                        seg_w   = CNT_W'(8);
                     end
                     LINE_VERT: begin
                        seg_val = {23'd0, 2'b11, nm2, 2'b01};
                        seg_w   = CNT_W'(8);
                     end
                     default: begin
                        seg_val = {24'd0, 2'b11, nm2, 1'b1};
                        seg_w   = CNT_W'(7);
                     end
                  endcase
               end
               3'd1: begin
                  seg_val = (q_head.form == LINE_VERT) ? q_head.fy : q_head.fx;
                  seg_w   = CNT_W'(q_head.n);
               end
               3'd2: begin
                  seg_val = q_head.fy;
                  seg_w   = CNT_W'(q_head.n);
               end
               default: begin
                  seg_val = '0;
                  seg_w   = '0;
               end
            endcase
         end
         OP_CURVE: begin
            seg_w = CNT_W'(q_head.n);
            case (step_ff)
               3'd0: begin
                  seg_val = {25'd0, 2'b10, nm2};
                  seg_w   = CNT_W'(6);
               end
               3'd1:    seg_val = q_head.fx;
               3'd2:    seg_val = q_head.fy;
               3'd3:    seg_val = sx_ext;
               3'd4:    seg_val = sy_ext;
               default: seg_w   = '0;
            endcase
         end
         default: begin
            // End of shape: six zero bits, then zeros up to the byte boundary.
            seg_val = '0;
            seg_w   = (step_ff == 3'd0) ? CNT_W'(6) : {3'd0, pad};
         end
      endcase
   end

   assign seg_masked = seg_val & ~({COORD_W{1'b1}} << seg_w);
   assign sum        = {1'b0, cnt_base} + {1'b0, seg_w};

   // A new record starts only once every whole byte of the previous one is out.
   assign can_start = !active_ff && (cnt_base < CNT_W'(8));
   assign err_go    = q_valid && q_head.error && !active_ff && (cnt_ff < CNT_W'(8))
                      && out_free;
   assign app       = q_valid && !q_head.error && (active_ff || can_start)
                      && (sum <= (CNT_W+1)'(ACC_W));
   assign fin       = app && (step_ff == q_head.last_step);
   assign q_pop     = err_go || fin;

   always_comb begin
      acc_in    = app ? ((acc_ff << seg_w) | {{(ACC_W-COORD_W){1'b0}}, seg_masked}) : acc_ff;
      cnt_in    = app ? sum[CNT_W-1:0] : cnt_base;
      step_in   = step_ff;
      active_in = active_ff;
      if (fin) begin
         step_in   = '0;
         active_in = 1'b0;
      end else if (app) begin
         step_in   = step_ff + STEP_W'(1);
         active_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_error_in = rsp_error_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = acc_down[INDEX_W-1:0];
         rsp_last_in  = !active_ff && (cnt_base < CNT_W'(8));
         rsp_error_in = 1'b0;
      end else if (err_go) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = '0;
         rsp_last_in  = 1'b1;
         rsp_error_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         step_ff      <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = rsp_byte_ff;
   assign rsp.last     = rsp_last_ff;
   assign rsp.error    = rsp_error_ff;

   `ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(ACC_W), "accumulator overrun")
   `ASSERT_IMPLIES(a_idle_step, clock, reset, !active_ff, step_ff == '0, "idle with step set")
   `ASSERT_NEXT(a_fin_idle, clock, reset, fin, !active_ff && step_ff == '0, "record not closed")
   `ASSERT_IMPLIES(a_err_beat, clock, reset, rsp_valid_ff && rsp_error_ff,
                   rsp_last_ff && rsp_byte_ff == '0, "malformed error beat")

endmodule

`default_nettype wire

[hdl/vector_shape_record_bit_packer.sv]
// Channel   Dir   Beat                                              Handshake
// req_ch    in    opcode, style_flags, first/second x,y, indices    valid/ready
// rsp_ch    out   out_byte, last, error                             valid/ready
// csr_*     in    csr_index selects fill or line index width        write enable
//
// The packer appends one field per cycle when there is room: two for an end or a
// horizontal or vertical line, three for a general line, five for a curve, four
// to seven for a style change. Bytes drain one per ready cycle, up to 10 for an
// edge and 13 for a full style change; a byte that may close its record is held
// until the record is complete. A two-entry queue parts the classifier from the
// packer and buffers requests during output stalls. Reset is synchronous: it
// empties the queue, clears the leftover bits and sets both index widths to zero.
`timescale 1ns / 1ps
`default_nettype none

module vector_shape_record_bit_packer import svrbp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   svrbp_req_if.sink        req_ch,
   svrbp_rsp_if.source      rsp_ch,
   input  logic             csr_write_enable,
   input  logic [0:0]       csr_index,
   input  logic [CSR_W-1:0] csr_write_data
);

   logic    q_push, q_full, q_pop, q_valid;
   rec_type q_rec, q_head;

   // Front: accept a beat, drop empty records, size the coordinates.
   svrbp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_rec            (q_rec)
   );

   // Hold classified records until the packer is free.
   svrbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (q_rec),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   // Back: append one field per cycle when there is room, drain one byte per ready cycle.
   svrbp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

endmodule

`default_nettype wire
